FILE: hdl/tpg_pkg.sv
// Tile test pattern generator package: request type, status and register
// codes, hash constants and tile geometry. No dependencies.
package tpg_pkg;

  localparam int TileSize = 256;
  localparam int CheckShift = 5;  // 32-pixel checker squares

  localparam int TileXW = 22;
  localparam int TileYW = 22;
  localparam int ZoomW  = 5;
  localparam int PixW   = 8;
  localparam int KeyW   = TileXW + TileYW + ZoomW;
  localparam int HashW  = 23;    // hash bits that reach the color
  localparam int CntW   = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = KeyW;

  localparam logic [31:0] MulX = 32'd2654435761;
  localparam logic [31:0] MulY = 32'd2246822519;
  localparam logic [31:0] MulZ = 32'd3266489917;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_IO_ERR  = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_IO_ERROR_LIMIT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MISSING_COUNT  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MISSING_TILE_0 = 3'd2;

  typedef struct packed {
    logic [PixW-1:0]   pixel_y;
    logic [PixW-1:0]   pixel_x;
    logic [ZoomW-1:0]  tile_zoom;
    logic [TileYW-1:0] tile_y;
    logic [TileXW-1:0] tile_x;
  } req_t;

  typedef struct packed {
    logic [CntW-1:0] io_error_limit;
    logic            missing_hit;
  } cfg_stat_t;

endpackage

FILE: hdl/tile_test_pattern_generator_unit.sv
// Tile test pattern generator top level: input stage, load counter, status
// and result register. Depends on tpg_pkg, tpg_cfg_regs, tpg_pixel_color.
// Registered path from input beat to output valid: input register, then result register.
// Throughput: one pixel per cycle; each stage advances when the next one is free.
// Reset (rst_n low, synchronous) clears the load counter, stage valids and all
// configuration registers.
module tile_test_pattern_generator_unit #(
  parameter int MISSING_SLOTS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // tile_x[21:0], tile_y[43:22], tile_zoom[48:44], pixel_x[56:49],
  // pixel_y[64:57], zero pad
  input  logic [71:0]                   in_tdata,
  // tile_start[0]
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // pixel_rgb565[15:0]
  output logic [15:0]                   out_tdata,
  // load_status[1:0]
  output logic [1:0]                    out_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tpg_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tpg_pkg::CfgDataW-1:0]  cfg_data
);

  tpg_pkg::req_t             s1_req_r;
  logic                      s1_valid_r;
  logic [tpg_pkg::CntW-1:0]  s1_cnt_r;
  logic [tpg_pkg::CntW-1:0]  load_count_r, load_count_nxt;
  logic                      out_valid_r;
  logic [15:0]               out_pix_r, out_pix_nxt;
  logic [1:0]                out_stat_r, out_stat_nxt;
  logic                      in_acc, s1_adv, out_free;
  tpg_pkg::cfg_stat_t        cstat;
  logic [15:0]               rgb;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    load_count_nxt = load_count_r;
    if (in_acc && in_tuser && load_count_r != '1) load_count_nxt = load_count_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      load_count_r <= load_count_nxt;
      if (in_tready) s1_valid_r <= in_tvalid;
      if (out_free) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r <= in_tdata[$bits(tpg_pkg::req_t)-1:0];
      s1_cnt_r <= load_count_nxt;
    end
    if (s1_adv) begin
      out_pix_r  <= out_pix_nxt;
      out_stat_r <= out_stat_nxt;
    end
  end

  tpg_cfg_regs #(
    .MISSING_SLOTS(MISSING_SLOTS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .key      ({s1_req_r.tile_x, s1_req_r.tile_y, s1_req_r.tile_zoom}),
    .stat     (cstat)
  );

  tpg_pixel_color u_color (
    .req   (s1_req_r),
    .rgb565(rgb)
  );

  always_comb begin
    if (cstat.missing_hit)
      out_stat_nxt = tpg_pkg::ST_MISSING;
    else if (cstat.io_error_limit != '0 && s1_cnt_r > cstat.io_error_limit)
      out_stat_nxt = tpg_pkg::ST_IO_ERR;
    else
      out_stat_nxt = tpg_pkg::ST_OK;
    out_pix_nxt = (out_stat_nxt == tpg_pkg::ST_OK) ? rgb : '0;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tuser  = out_stat_r;

  a_pix_zero_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != tpg_pkg::ST_OK |-> out_tdata == '0)
    else $error("nonzero pixel with failing status");

  a_stat_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("undefined load status");

  a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> load_count_r >= $past(load_count_r))
    else $error("load counter went backward");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted beat lost in input stage");

endmodule

FILE: hdl/tpg_cfg_regs.sv
// Configuration registers and missing-tile lookup for the tile pattern
// generator. Depends on tpg_pkg.
module tpg_cfg_regs #(
  parameter int MISSING_SLOTS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [tpg_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [tpg_pkg::CfgDataW-1:0]    cfg_data,
  input  logic [tpg_pkg::KeyW-1:0]        key,
  output tpg_pkg::cfg_stat_t              stat
);

  logic [tpg_pkg::CntW-1:0]  io_error_limit_r;
  logic [2:0]                missing_count_r;
  logic [tpg_pkg::KeyW-1:0]  missing_tile_r [MISSING_SLOTS];
  logic                      hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      io_error_limit_r <= '0;
      missing_count_r  <= '0;
      for (int i = 0; i < MISSING_SLOTS; i++) missing_tile_r[i] <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == tpg_pkg::REG_IO_ERROR_LIMIT)
        io_error_limit_r <= cfg_data[tpg_pkg::CntW-1:0];
      if (cfg_index == tpg_pkg::REG_MISSING_COUNT)
        missing_count_r <= cfg_data[2:0];
      for (int i = 0; i < MISSING_SLOTS; i++) begin
        if (cfg_index == tpg_pkg::REG_MISSING_TILE_0 + tpg_pkg::CfgIdxW'(i))
          missing_tile_r[i] <= cfg_data;
      end
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < MISSING_SLOTS; i++) begin
      if (3'(i) < missing_count_r && missing_tile_r[i] == key) hit = 1'b1;
    end
  end

  assign stat.io_error_limit = io_error_limit_r;
  assign stat.missing_hit    = hit;

endmodule

FILE: hdl/tpg_pixel_color.sv
// Tile hash, checkerboard and border logic giving the RGB565 pixel of a
// request. Depends on tpg_pkg.
module tpg_pixel_color (
  input  tpg_pkg::req_t req,
  output logic [15:0]   rgb565
);

  localparam logic [9:0] Last = 10'(tpg_pkg::TileSize - 1);

  logic [tpg_pkg::HashW-1:0] px_hx, px_hy, px_hz, h;
  logic                      border, bright;

  // only the low hash bits feed the channels, so the products are truncated
  assign px_hx = tpg_pkg::HashW'(tpg_pkg::HashW'(req.tile_x) * tpg_pkg::MulX[tpg_pkg::HashW-1:0]);
  assign px_hy = tpg_pkg::HashW'(tpg_pkg::HashW'(req.tile_y) * tpg_pkg::MulY[tpg_pkg::HashW-1:0]);
  assign px_hz = tpg_pkg::HashW'(tpg_pkg::HashW'(req.tile_zoom) * tpg_pkg::MulZ[tpg_pkg::HashW-1:0]);
  assign h = px_hx ^ px_hy ^ px_hz;

  assign border = (req.pixel_x == '0) || (req.pixel_y == '0) ||
                  ({2'b00, req.pixel_x} == Last) || ({2'b00, req.pixel_y} == Last);
  assign bright = ~(req.pixel_x[tpg_pkg::CheckShift] ^ req.pixel_y[tpg_pkg::CheckShift]);

  always_comb begin
    if (border)
      rgb565 = '0;
    else if (bright)
      rgb565 = {1'b1, h[6:3], 1'b1, h[14:10], 1'b1, h[22:19]};
    else
      rgb565 = {2'b01, h[6:4], 2'b01, h[14:11], 2'b01, h[22:20]};
  end

endmodule

FILE: tb/tb_tile_test_pattern_generator_unit.sv
// Testbench for tile_test_pattern_generator_unit: drives pixel requests and
// register writes, predicts each pixel and load status, and checks every beat.
// Depends on tpg_pkg and the tile_test_pattern_generator_unit RTL.
module tb_tile_test_pattern_generator_unit;

  localparam int MISSING_SLOTS = 4;
  localparam int HOLD_CYCLES   = 60;
  localparam int LAT_CYCLES    = 4;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASE_ITEMS   = 140;

  localparam logic [tpg_pkg::CfgIdxW-1:0] REG_MISSING_TILE_3 =
    tpg_pkg::REG_MISSING_TILE_0 + 3'd3;
  localparam logic [tpg_pkg::CfgIdxW-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [tpg_pkg::CfgIdxW-1:0] REG_SPARE_7 = 3'd7;

  typedef struct {
    logic [15:0] rgb;
    logic [1:0]  status;
  } pixel_result_t;

  class pixel_predictor;
    logic [15:0]              err_limit;
    logic [2:0]               miss_n;
    logic [tpg_pkg::KeyW-1:0] miss_key [MISSING_SLOTS];
    logic [15:0]              loads;
    pixel_result_t            expected_pixels [$];
    int errors, checked, n_ok, n_miss, n_ioerr;

    function new();
      err_limit = '0;
      miss_n    = '0;
      loads     = '0;
      foreach (miss_key[i]) miss_key[i] = '0;
      errors = 0; checked = 0; n_ok = 0; n_miss = 0; n_ioerr = 0;
    endfunction

    function void set_reg(logic [tpg_pkg::CfgIdxW-1:0] idx,
                          logic [tpg_pkg::CfgDataW-1:0] data);
      case (idx)
        tpg_pkg::REG_IO_ERROR_LIMIT: err_limit = data[15:0];
        tpg_pkg::REG_MISSING_COUNT:  miss_n = data[2:0];
        default: begin
          if (idx >= tpg_pkg::REG_MISSING_TILE_0 && idx <= REG_MISSING_TILE_3)
            miss_key[idx - tpg_pkg::REG_MISSING_TILE_0] = data;
        end
      endcase
    endfunction

    function void note_request(tpg_pkg::req_t r, logic start);
      pixel_result_t e;
      logic [31:0] h;
      logic [7:0] red, grn, blu;
      int slots;
      bit on_border, bright;
      if (start && loads != 16'hFFFF) loads++;
      e.status = tpg_pkg::ST_OK;
      e.rgb = '0;
      slots = (miss_n < MISSING_SLOTS) ? miss_n : MISSING_SLOTS;
      for (int i = 0; i < slots; i++)
        if (miss_key[i] == {r.tile_x, r.tile_y, r.tile_zoom}) e.status = tpg_pkg::ST_MISSING;
      if (e.status == tpg_pkg::ST_OK && err_limit != 0 && loads > err_limit)
        e.status = tpg_pkg::ST_IO_ERR;
      if (e.status == tpg_pkg::ST_OK) begin
        h = (32'(r.tile_x) * tpg_pkg::MulX) ^ (32'(r.tile_y) * tpg_pkg::MulY) ^
            (32'(r.tile_zoom) * tpg_pkg::MulZ);
        red = 8'd128 + {1'b0, h[6:0]};
        grn = 8'd128 + {1'b0, h[14:8]};
        blu = 8'd128 + {1'b0, h[22:16]};
        on_border = r.pixel_x == 0 || r.pixel_y == 0 ||
                    r.pixel_x == tpg_pkg::TileSize - 1 || r.pixel_y == tpg_pkg::TileSize - 1;
        bright = (((r.pixel_x >> tpg_pkg::CheckShift) +
                   (r.pixel_y >> tpg_pkg::CheckShift)) & 1) == 0;
        if (!on_border) begin
          if (!bright) begin
            red = red >> 1;
            grn = grn >> 1;
            blu = blu >> 1;
          end
          e.rgb = {red[7:3], grn[7:2], blu[7:3]};
        end
      end
      expected_pixels.push_back(e);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", msg);
    endtask

    task check_pixel(logic [15:0] rgb, logic [1:0] st);
      pixel_result_t e;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected beat rgb=%h status=%0d", rgb, st));
        return;
      end
      e = expected_pixels.pop_front();
      checked++;
      case (e.status)
        tpg_pkg::ST_OK:      n_ok++;
        tpg_pkg::ST_MISSING: n_miss++;
        default:             n_ioerr++;
      endcase
      if (st !== e.status)
        report_mismatch($sformatf("pixel %0d status %0d, want %0d", checked, st, e.status));
      if (rgb !== e.rgb)
        report_mismatch($sformatf("pixel %0d rgb %h, want %h", checked, rgb, e.rgb));
    endtask
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [71:0]                  in_tdata;
  logic                         in_tuser;
  logic                         out_tvalid;
  logic                         out_tready;
  logic [15:0]                  out_tdata;
  logic [1:0]                   out_tuser;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [tpg_pkg::CfgIdxW-1:0]  cfg_index;
  logic [tpg_pkg::CfgDataW-1:0] cfg_data;

  bit tx_idle, rx_idle, hold_req;
  pixel_predictor sb;

  tile_test_pattern_generator_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("tb_tile_test_pattern_generator_unit: done, errors");
    $finish;
  end

  // receiver: random stall bursts plus one long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_pixel(out_tdata, out_tuser);
  end

  function automatic tpg_pkg::req_t make_req(logic [tpg_pkg::KeyW-1:0] key,
                                             logic [7:0] px, logic [7:0] py);
    tpg_pkg::req_t r;
    {r.tile_x, r.tile_y, r.tile_zoom} = key;
    r.pixel_x = px;
    r.pixel_y = py;
    return r;
  endfunction

  function automatic logic [tpg_pkg::KeyW-1:0] rand_key();
    return tpg_pkg::KeyW'({$urandom, $urandom});
  endfunction

  function automatic logic [7:0] rand_coord();
    logic [7:0] corner [6];
    corner = '{8'd0, 8'd1, 8'd31, 8'd32, 8'd254, 8'd255};
    if ($urandom_range(0, 4) == 0) return corner[$urandom_range(0, 5)];
    return 8'($urandom);
  endfunction

  task automatic send_pixel(input tpg_pkg::req_t r, input logic start);
    int gap;
    if (tx_idle && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= 72'(r);
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(r, start);
  endtask

  task automatic write_reg(input logic [tpg_pkg::CfgIdxW-1:0] idx,
                           input logic [tpg_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (LAT_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [15:0] lim, input logic [2:0] n,
                               input logic [3:0][tpg_pkg::KeyW-1:0] keys);
    settle();
    for (int i = 0; i < MISSING_SLOTS; i++)
      write_reg(tpg_pkg::REG_MISSING_TILE_0 + tpg_pkg::CfgIdxW'(i), keys[i]);
    write_reg(tpg_pkg::REG_MISSING_COUNT, tpg_pkg::CfgDataW'(n));
    write_reg(tpg_pkg::REG_IO_ERROR_LIMIT, tpg_pkg::CfgDataW'(lim));
  endtask

  // one tile: start beat then pixels of the same tile; some runs are broken
  task automatic send_tile_run(output int sent);
    logic [tpg_pkg::KeyW-1:0] key;
    int sel, len;
    bit broken;
    logic start;
    sel = $urandom_range(0, 9);
    if (sel < 3) key = sb.miss_key[$urandom_range(0, MISSING_SLOTS - 1)];
    else if (sel == 3)
      key = sb.miss_key[$urandom_range(0, MISSING_SLOTS - 1)] ^
            (tpg_pkg::KeyW'(1) << $urandom_range(0, tpg_pkg::KeyW - 1));
    else if (sel == 4) key = $urandom_range(0, 1) ? '1 : '0;
    else key = rand_key();
    len = $urandom_range(1, 12);
    broken = $urandom_range(0, 9) == 0;
    for (int i = 0; i < len; i++) begin
      start = broken ? 1'($urandom_range(0, 1)) : (i == 0);
      send_pixel(make_req(key, rand_coord(), rand_coord()), start);
    end
    sent = len;
  endtask

  initial begin
    logic [3:0][tpg_pkg::KeyW-1:0] keys;
    logic [tpg_pkg::KeyW-1:0] k_rand;
    logic [15:0] lim;
    logic [2:0] miss_sel [8];
    int sent, total;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_req = 1'b0;
    sb = new();
    miss_sel = '{3'd0, 3'd1, 3'd4, 3'd2, 3'd7, 3'd5, 3'd3, 3'd4};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults after reset: nothing missing, injection off
    k_rand = rand_key();
    send_pixel(make_req('0, 8'd1, 8'd1), 1'b1);
    send_pixel(make_req('1, 8'd255, 8'd255), 1'b0);
    send_pixel(make_req(k_rand, 8'd0, 8'd100), 1'b0);
    send_pixel(make_req(k_rand, 8'd100, 8'd0), 1'b0);
    send_pixel(make_req(k_rand, 8'd33, 8'd5), 1'b0);
    send_pixel(make_req('1, 8'd64, 8'd64), 1'b0);
    send_pixel(make_req(rand_key(), 8'd254, 8'd254), 1'b0);
    send_pixel(make_req(rand_key(), 8'd31, 8'd32), 1'b0);

    // missing list full, limit just above the current load count
    keys = {rand_key(), rand_key(), tpg_pkg::KeyW'(0), {tpg_pkg::KeyW{1'b1}}};
    apply_setting(sb.loads + 16'd2, 3'd4, keys);
    write_reg(REG_SPARE_6, rand_key());
    write_reg(REG_SPARE_7, '1);
    send_pixel(make_req(keys[0], 8'd40, 8'd40), 1'b1);
    send_pixel(make_req(keys[1], rand_coord(), rand_coord()), 1'b0);
    k_rand = rand_key();
    send_pixel(make_req(k_rand, 8'd70, 8'd90), 1'b1);
    send_pixel(make_req(k_rand, 8'd70, 8'd91), 1'b1);
    send_pixel(make_req(k_rand, 8'd100, 8'd120), 1'b0);
    send_pixel(make_req(keys[2], 8'd50, 8'd60), 1'b1);
    send_pixel(make_req(rand_key(), 8'd80, 8'd80), 1'b0);

    // count beyond the slot number; injection off
    apply_setting(16'd0, 3'd7, keys);
    send_pixel(make_req(keys[3], 8'd10, 8'd10), 1'b0);
    send_pixel(make_req(rand_key(), 8'd10, 8'd10), 1'b1);
    settle();
    write_reg(tpg_pkg::REG_MISSING_COUNT, tpg_pkg::CfgDataW'(1));
    send_pixel(make_req(keys[2], 8'd12, 8'd200), 1'b0);
    send_pixel(make_req(keys[0], 8'd200, 8'd12), 1'b0);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0, 5:    lim = 16'd0;
        2:       lim = 16'hFFFF;
        3:       lim = 16'd1;
        7:       lim = 16'($urandom);
        default: lim = sb.loads + 16'($urandom_range(5, 60));
      endcase
      for (int i = 0; i < MISSING_SLOTS; i++) keys[i] = rand_key();
      if (p == 1) begin
        keys[0] = '1;
        keys[1] = '0;
      end
      if (p >= 6) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      apply_setting(lim, miss_sel[p], keys);
      total = 0;
      while (total < PHASE_ITEMS) begin
        if (p == 2 && total >= 20 && total < 32) hold_req = 1'b1;
        send_tile_run(sent);
        total += sent;
        hold_req = 1'b0;
      end
    end

    // high limit, then a limit just under the load count, then injection off
    apply_setting(16'hFFFF, 3'd0, keys);
    repeat (20) send_pixel(make_req(rand_key(), rand_coord(), rand_coord()), 1'b1);
    settle();
    write_reg(tpg_pkg::REG_IO_ERROR_LIMIT, tpg_pkg::CfgDataW'(sb.loads - 16'd3));
    repeat (20) send_pixel(make_req(rand_key(), rand_coord(), rand_coord()), 1'($urandom));
    settle();
    write_reg(tpg_pkg::REG_IO_ERROR_LIMIT, '0);
    repeat (20) send_pixel(make_req(rand_key(), rand_coord(), rand_coord()), 1'b1);

    settle();
    if (sb.expected_pixels.size() != 0) sb.report_mismatch("pixels never delivered");
    $display("checked %0d pixels: %0d ok, %0d missing tile, %0d injected io error",
             sb.checked, sb.n_ok, sb.n_miss, sb.n_ioerr);
    $display("load counter ended at %0d after eleven register settings and a long stall",
             sb.loads);
    if (sb.errors == 0) begin
      $display("tb_tile_test_pattern_generator_unit: done, clean");
    end else begin
      $display("tb_tile_test_pattern_generator_unit: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/tpg_pkg.sv
hdl/tpg_cfg_regs.sv
hdl/tpg_pixel_color.sv
hdl/tile_test_pattern_generator_unit.sv
tb/tb_tile_test_pattern_generator_unit.sv
